>>> hw/rtl/wpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared constants and types for the waveform peak decimator: frame counter
// width and configuration register map.
// ----------------------------------------------------------------------------
package wpd_pkg;

    localparam int FRAME_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    typedef logic [FRAME_W-1:0]    frame_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // Configuration register map.
    localparam cfg_idx_t REG_TOTAL_FRAMES = cfg_idx_t'(0);
    localparam cfg_idx_t REG_MONO_MODE    = cfg_idx_t'(1);

endpackage

>>> hw/rtl/waveform_peak_decimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_peak_decimator
// Folds a stream of stereo frames into BUCKETS peak-magnitude buckets for a
// waveform overview and reports each frame's bucket and its updated peak.
// ----------------------------------------------------------------------------
// A word accepted on the input passes the read stage and then the output register to the result port.
// Throughput: one word per cycle while total_frames >= BUCKETS and the result port does not stall.
//   With a shorter track a frame that moves buckets holds the input while the pending loop walks them.
// A total_frames write rebuilds the bucket position with the divider, input held.
// Reset: control state returns to its defaults and a clearing pass zeroes the peak memory,
//   one entry per cycle, before input opens.
// ----------------------------------------------------------------------------
module waveform_peak_decimator
    import wpd_pkg::*;
#(
    parameter int BUCKETS     = 512,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  cfg_idx_t                       cfg_index,
    input  cfg_data_t                      cfg_data,

    // Frame input channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_BITS-1:0]  s_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]  s_right_sample,
    input  logic                           s_left_bad,
    input  logic                           s_right_bad,

    // Result channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [$clog2(BUCKETS)-1:0]     m_bucket_index,
    output logic [SAMPLE_BITS-1:0]         m_bucket_peak,
    output logic                           m_final_frame
);

    localparam int BW     = $clog2(BUCKETS);
    localparam int NUM_W  = FRAME_W + BW;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    localparam logic [BW-1:0]          LAST_BUCKET = BW'(BUCKETS - 1);
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [FRAME_W:0]       BUCKETS_EXT = (FRAME_W+1)'(BUCKETS);
    localparam logic signed [FRAME_W+1:0] TMB_RESET = (FRAME_W+2)'(1 - BUCKETS);

    // ------------------------------------------------------------------------
    // Configuration registers. Alongside the total we keep total-1 for the
    // final-frame compare and total-BUCKETS so that the per-frame bucket step
    // is a single subtract.
    // ------------------------------------------------------------------------
    frame_t                    total_reg;
    frame_t                    tm1_reg;
    logic signed [FRAME_W+1:0] tmb_reg;
    logic                      small_total_reg;
    logic                      mono_mode_reg;

    logic   cfg_write;
    logic   total_write;
    frame_t total_eff;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign total_write = cfg_write && (cfg_index == REG_TOTAL_FRAMES);
    // A total of zero behaves as a total of one.
    assign total_eff   = (cfg_data == '0) ? frame_t'(1) : cfg_data;

    // ------------------------------------------------------------------------
    // Frame magnitude. A flagged sample counts as zero; in mono mode the right
    // channel, flag included, is a copy of the left. The most negative code
    // negates to exactly full scale, so no further cap is needed.
    // ------------------------------------------------------------------------
    function automatic logic [SAMPLE_BITS-1:0] sample_mag(
        input logic [SAMPLE_BITS-1:0] v,
        input logic                   bad
    );
        logic [SAMPLE_BITS-1:0] m;
        m = v[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - v) : v;
        return bad ? '0 : m;
    endfunction

    logic [SAMPLE_BITS-1:0] l_mag;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [SAMPLE_BITS-1:0] frame_mag;

    assign l_mag     = sample_mag(s_left_sample, s_left_bad);
    assign r_mag     = mono_mode_reg ? l_mag : sample_mag(s_right_sample, s_right_bad);
    assign frame_mag = (l_mag > r_mag) ? l_mag : r_mag;

    // ------------------------------------------------------------------------
    // Bucket position. We hold the invariant frame*BUCKETS =
    // bucket*total + rem with rem < total, and step it as frames arrive. The
    // bucket stops at the last one; from there rem is no longer tracked.
    // ------------------------------------------------------------------------
    frame_t          frame_reg;
    logic [BW-1:0]   bucket_reg;
    frame_t          rem_reg;
    logic            pend_reg;

    logic                      div_busy_reg;
    logic [DCNT_W-1:0]         div_cnt_reg;
    frame_t                    div_rem_reg;
    logic [NUM_W-1:0]          div_num_reg;

    logic                      clr_busy_reg;
    logic [BW-1:0]             clr_addr_reg;

    logic                      st1_valid_reg;
    logic [BW-1:0]             st1_idx_reg;
    logic [SAMPLE_BITS-1:0]    st1_mag_reg;
    logic                      st1_final_reg;
    logic [SAMPLE_BITS-1:0]    rd_data_reg;

    logic                      wb_valid_reg;
    logic [BW-1:0]             wb_idx_reg;
    logic [SAMPLE_BITS-1:0]    wb_peak_reg;

    logic                      m_valid_reg;
    logic [BW-1:0]             m_bucket_index_reg;
    logic [SAMPLE_BITS-1:0]    m_bucket_peak_reg;
    logic                      m_final_frame_reg;

    logic st1_move;
    logic accept;

    assign st1_move = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !clr_busy_reg && !div_busy_reg && !pend_reg &&
                      (!st1_valid_reg || st1_move);
    assign accept   = s_valid && s_ready;

    // Advance on an accepted frame: add BUCKETS to rem and take at most one
    // bucket step here; short tracks finish the walk in the pending loop.
    logic [BW-1:0]             bucket_inc;
    logic [FRAME_W:0]          step_sum;
    logic signed [FRAME_W+1:0] step_diff;
    logic [BW-1:0]             adv_bucket_next;
    frame_t                    adv_rem_next;
    logic                      adv_pend_next;

    assign bucket_inc = bucket_reg + 1'b1;
    assign step_sum   = {1'b0, rem_reg} + BUCKETS_EXT;
    assign step_diff  = $signed({2'b00, rem_reg}) - tmb_reg;

    always_comb begin
        adv_bucket_next = bucket_reg;
        adv_rem_next    = rem_reg;
        adv_pend_next   = 1'b0;
        priority if (frame_reg == '1) begin
            // The frame counter wraps to zero, which lands in bucket zero.
            adv_bucket_next = '0;
            adv_rem_next    = '0;
        end else if (bucket_reg != LAST_BUCKET) begin
            if (!step_diff[FRAME_W+1]) begin
                adv_bucket_next = bucket_inc;
                adv_rem_next    = step_diff[FRAME_W-1:0];
                adv_pend_next   = small_total_reg && (bucket_inc != LAST_BUCKET);
            end else begin
                adv_rem_next    = step_sum[FRAME_W-1:0];
            end
        end else begin
            // The last bucket holds until the frame counter wraps.
        end
    end

    // One extra bucket step per cycle while rem still reaches the total, short of the last bucket.
    logic [FRAME_W:0] pend_diff;
    logic             pend_take;

    assign pend_diff = {1'b0, rem_reg} - {1'b0, total_reg};
    assign pend_take = !pend_diff[FRAME_W] && (bucket_reg != LAST_BUCKET);

    // Restoring divider, one quotient bit per cycle: frame*BUCKETS / total.
    // The quotient shifts into the dividend register from the bottom.
    logic [FRAME_W:0]  div_trial;
    logic              div_ge;
    frame_t            div_rem_next;
    logic [NUM_W-1:0]  div_num_next;
    logic [BW-1:0]     div_bucket_next;

    assign div_trial    = {div_rem_reg, div_num_reg[NUM_W-1]};
    assign div_ge       = div_trial >= {1'b0, total_reg};
    assign div_rem_next = div_ge ? FRAME_W'(div_trial - {1'b0, total_reg})
                                 : div_trial[FRAME_W-1:0];
    assign div_num_next = {div_num_reg[NUM_W-2:0], div_ge};
    assign div_bucket_next = (div_num_next > NUM_W'(LAST_BUCKET)) ? LAST_BUCKET
                                                                  : div_num_next[BW-1:0];

    // ------------------------------------------------------------------------
    // Peak memory: one read port issued on accept, one write port shared by
    // the clearing pass and the update stage.
    // ------------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] peak_mem [BUCKETS];

    logic                   mem_we;
    logic [BW-1:0]          mem_waddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;
    logic [SAMPLE_BITS-1:0] st1_old;
    logic [SAMPLE_BITS-1:0] st1_peak;

    // The only write the registered read can miss is the one made in the same
    // cycle, which is always the most recent write, so one bypass register
    // covers it.
    assign st1_old  = (wb_valid_reg && (wb_idx_reg == st1_idx_reg)) ? wb_peak_reg
                                                                    : rd_data_reg;
    assign st1_peak = (st1_mag_reg > st1_old) ? st1_mag_reg : st1_old;

    assign mem_we    = clr_busy_reg || st1_move;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : st1_idx_reg;
    assign mem_wdata = clr_busy_reg ? '0 : st1_peak;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            peak_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rd_data_reg <= peak_mem[bucket_reg];
        end
    end

    // ------------------------------------------------------------------------
    // Control and bucket state.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg       <= frame_t'(1);
            tm1_reg         <= '0;
            tmb_reg         <= TMB_RESET;
            small_total_reg <= 1'b1;
            mono_mode_reg   <= 1'b0;
            frame_reg       <= '0;
            bucket_reg      <= '0;
            rem_reg         <= '0;
            pend_reg        <= 1'b0;
            div_busy_reg    <= 1'b0;
            div_cnt_reg     <= '0;
            clr_busy_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            st1_valid_reg   <= 1'b0;
            wb_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            // Configuration writes.
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_TOTAL_FRAMES: begin
                        total_reg       <= total_eff;
                        tm1_reg         <= total_eff - 1'b1;
                        tmb_reg         <= $signed({2'b00, total_eff}) -
                                           $signed({1'b0, BUCKETS_EXT});
                        small_total_reg <= {1'b0, total_eff} < BUCKETS_EXT;
                    end
                    REG_MONO_MODE: begin
                        mono_mode_reg   <= cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end

            // Bucket position: rebuild on a new total, else step per frame.
            priority if (total_write) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= DCNT_W'(NUM_W);
                div_rem_reg  <= '0;
                div_num_reg  <= NUM_W'(frame_reg) * NUM_W'(BUCKETS);
                pend_reg     <= 1'b0;
            end else if (div_busy_reg) begin
                div_rem_reg  <= div_rem_next;
                div_num_reg  <= div_num_next;
                div_cnt_reg  <= div_cnt_reg - 1'b1;
                if (div_cnt_reg == DCNT_W'(1)) begin
                    div_busy_reg <= 1'b0;
                    bucket_reg   <= div_bucket_next;
                    rem_reg      <= div_rem_next;
                end
            end else if (accept) begin
                frame_reg  <= frame_reg + 1'b1;
                bucket_reg <= adv_bucket_next;
                rem_reg    <= adv_rem_next;
                pend_reg   <= adv_pend_next;
            end else if (pend_reg) begin
                if (pend_take) begin
                    bucket_reg <= bucket_inc;
                    rem_reg    <= pend_diff[FRAME_W-1:0];
                    pend_reg   <= (bucket_inc != LAST_BUCKET);
                end else begin
                    pend_reg   <= 1'b0;
                end
            end else begin
                // Nothing moves the bucket position this cycle.
            end

            // Clearing pass over the peak memory after reset.
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_BUCKET) begin
                    clr_busy_reg <= 1'b0;
                end
            end

            // Read stage.
            if (accept) begin
                st1_valid_reg <= 1'b1;
                st1_idx_reg   <= bucket_reg;
                st1_mag_reg   <= frame_mag;
                st1_final_reg <= (frame_reg == tm1_reg);
            end else if (st1_move) begin
                st1_valid_reg <= 1'b0;
            end

            // Update stage and output register.
            if (st1_move) begin
                wb_valid_reg       <= 1'b1;
                wb_idx_reg         <= st1_idx_reg;
                wb_peak_reg        <= st1_peak;
                m_valid_reg        <= 1'b1;
                m_bucket_index_reg <= st1_idx_reg;
                m_bucket_peak_reg  <= st1_peak;
                m_final_frame_reg  <= st1_final_reg;
            end else if (m_ready) begin
                m_valid_reg        <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_bucket_index = m_bucket_index_reg;
    assign m_bucket_peak  = m_bucket_peak_reg;
    assign m_final_frame  = m_final_frame_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_no_input_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_ready
    ) else $error("input opened during the peak memory clearing pass");

    a_total_write_holds_input: assert property (
        @(posedge aclk) disable iff (!aresetn)
        total_write |=> !s_ready
    ) else $error("input opened before the bucket position was rebuilt");

    a_peak_in_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_bucket_peak_reg <= FULL_SCALE)
    ) else $error("reported peak exceeds full scale");

    a_bucket_in_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_ready |-> (bucket_reg <= LAST_BUCKET)
    ) else $error("bucket position beyond the last bucket");

endmodule

>>> sim/tb_waveform_peak_decimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waveform_peak_decimator
// Self-checking bench for the waveform peak decimator. A driver offers stereo
// frame words from a queue and a monitor takes result words. Both sides idle at
// random. Each accepted frame is folded into a local copy of the frame counter
// and the peak buckets, and every result word is checked against the oldest
// prediction. The run moves through a set of track lengths and mono settings,
// including a zero length, a length of one and the largest length.
// ----------------------------------------------------------------------------
module tb_waveform_peak_decimator;
    import wpd_pkg::*;

    localparam int BUCKETS     = 512;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(BUCKETS);
    localparam int FULL_SCALE  = 1 << (SAMPLE_BITS - 1);
    // Far above the slowest legal run: the clearing pass, one divider run and
    // one full bucket walk per setting, and every word waiting out the
    // receiver's stalls and the two long hold-offs.
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_FRAMES = 650;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          left_bad;
        logic                          right_bad;
    } stereo_frame_t;

    typedef struct packed {
        logic [IDX_W-1:0]       bucket_index;
        logic [SAMPLE_BITS-1:0] bucket_peak;
        logic                   final_frame;
    } bucket_report_t;

    logic                          aclk;
    logic                          aresetn        = 1'b0;
    logic                          cfg_valid      = 1'b0;
    logic                          cfg_ready;
    cfg_idx_t                      cfg_index      = REG_TOTAL_FRAMES;
    cfg_data_t                     cfg_data       = '0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_left_sample  = '0;
    logic signed [SAMPLE_BITS-1:0] s_right_sample = '0;
    logic                          s_left_bad     = 1'b0;
    logic                          s_right_bad    = 1'b0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic [IDX_W-1:0]              m_bucket_index;
    logic [SAMPLE_BITS-1:0]        m_bucket_peak;
    logic                          m_final_frame;

    waveform_peak_decimator #(
        .BUCKETS    (BUCKETS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_left_sample (s_left_sample),
        .s_right_sample(s_right_sample),
        .s_left_bad    (s_left_bad),
        .s_right_bad   (s_right_bad),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bucket_index(m_bucket_index),
        .m_bucket_peak (m_bucket_peak),
        .m_final_frame (m_final_frame)
    );

    // Local copy of the block's registers and state, kept in step with the
    // words that actually cross the handshakes.
    logic [31:0]            track_total  = 32'd1;
    logic                   track_mono   = 1'b0;
    logic [31:0]            track_frames = '0;
    logic [SAMPLE_BITS-1:0] track_peaks [BUCKETS] = '{default: '0};

    stereo_frame_t  frames_waiting [$];
    bucket_report_t reports_due [$];
    stereo_frame_t  offered;
    bit             offer_pending = 1'b0;
    bucket_report_t oldest;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int frames_sent   = 0;
    int results_seen  = 0;
    int finals_seen   = 0;
    int regs_written  = 0;
    int cycles        = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog. A hung handshake ends the run here.
    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due.",
                     cycles, reports_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Magnitude of one Q1.15 sample. A flagged sample counts as zero and the
    // most negative code maps to exactly full scale.
    function automatic logic [SAMPLE_BITS-1:0] sample_magnitude(
        logic signed [SAMPLE_BITS-1:0] sample, logic bad);
        int mag;
        if (bad)
            return '0;
        mag = int'(sample);
        if (mag < 0)
            mag = -mag;
        if (mag > FULL_SCALE)
            mag = FULL_SCALE;
        return mag[SAMPLE_BITS-1:0];
    endfunction

    // Folds one frame into the local peak buckets and returns the report the
    // block should give for it. The bucket is frame * BUCKETS / total, held at
    // the last bucket once the frame runs past the end of the track.
    function automatic bucket_report_t fold_frame(stereo_frame_t f);
        logic signed [SAMPLE_BITS-1:0] right;
        logic                          right_bad;
        logic [SAMPLE_BITS-1:0]        lmag, rmag, mag;
        logic [63:0]                   denom, slot;
        bucket_report_t                rep;
        right     = track_mono ? f.left_sample : f.right_sample;
        right_bad = track_mono ? f.left_bad : f.right_bad;
        lmag = sample_magnitude(f.left_sample, f.left_bad);
        rmag = sample_magnitude(right, right_bad);
        mag  = (lmag > rmag) ? lmag : rmag;
        // A track length of zero behaves as a length of one.
        denom = (track_total == '0) ? 64'd1 : {32'd0, track_total};
        slot  = ({32'd0, track_frames} * 64'(BUCKETS)) / denom;
        if (slot > 64'(BUCKETS - 1))
            slot = 64'(BUCKETS - 1);
        if (mag > track_peaks[slot])
            track_peaks[slot] = mag;
        rep.bucket_index = slot[IDX_W-1:0];
        rep.bucket_peak  = track_peaks[slot];
        rep.final_frame  = ({32'd0, track_frames} == denom - 64'd1);
        track_frames = track_frames + 32'd1;
        return rep;
    endfunction

    // Mostly small magnitudes so that bucket peaks keep moving, with full
    // random codes and the corner codes mixed in.
    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        logic signed [SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 7))
            0: v = SAMPLE_BITS'($urandom);
            1: begin
                case ($urandom_range(0, 5))
                    0: v = -16'sd32768;
                    1: v = 16'sd32767;
                    2: v = -16'sd32767;
                    3: v = -16'sd1;
                    4: v = 16'sd1;
                    default: v = '0;
                endcase
            end
            default: begin
                v = SAMPLE_BITS'($urandom_range(0, 32767) >> $urandom_range(0, 14));
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // Frame driver. The offered word is folded into the prediction at the edge
    // where it is taken; a new word is only loaded once the slot is free, so
    // valid is never dropped while a word waits.
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            reports_due.push_back(fold_frame(offered));
            offer_pending = 1'b0;
            frames_sent++;
        end
        if (!s_valid || s_ready) begin
            if (frames_waiting.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                offered = frames_waiting.pop_front();
                offer_pending = 1'b1;
                s_valid        <= 1'b1;
                s_left_sample  <= offered.left_sample;
                s_right_sample <= offered.right_sample;
                s_left_bad     <= offered.left_bad;
                s_right_bad    <= offered.right_bad;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor. Twice in the run the receiver stops taking words for a
    // long stretch so the result path backs up into the frame input.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (reports_due.size() == 0) begin
                $display("%0t: unexpected result word: bucket %0d peak %0d final %0b",
                         $time, m_bucket_index, m_bucket_peak, m_final_frame);
                mismatches++;
            end else begin
                oldest = reports_due.pop_front();
                if (m_bucket_index !== oldest.bucket_index) begin
                    $display("%0t: bucket_index expected %0d, got %0d",
                             $time, oldest.bucket_index, m_bucket_index);
                    mismatches++;
                end
                if (m_bucket_peak !== oldest.bucket_peak) begin
                    $display("%0t: bucket_peak expected %0d, got %0d",
                             $time, oldest.bucket_peak, m_bucket_peak);
                    mismatches++;
                end
                if (m_final_frame !== oldest.final_frame) begin
                    $display("%0t: final_frame expected %0b, got %0b",
                             $time, oldest.final_frame, m_final_frame);
                    mismatches++;
                end
            end
            if (m_final_frame)
                finals_seen++;
            results_seen++;
            if (results_seen == 60 || results_seen == 560)
                hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Register write. The local copy changes at the accepting edge; writes are
    // only issued with no frame in flight.
    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_TOTAL_FRAMES)
            track_total = value;
        else
            track_mono = value[0];
        regs_written++;
    endtask

    task automatic queue_frame(input logic signed [SAMPLE_BITS-1:0] left,
                               input logic signed [SAMPLE_BITS-1:0] right,
                               input logic left_bad, input logic right_bad);
        stereo_frame_t f;
        f.left_sample  = left;
        f.right_sample = right;
        f.left_bad     = left_bad;
        f.right_bad    = right_bad;
        frames_waiting.push_back(f);
    endtask

    // Every frame gives exactly one result, so once nothing is queued, offered
    // or due, the block is idle.
    task automatic wait_drained();
        while (frames_waiting.size() != 0 || offer_pending || reports_due.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int          random_sent;
        int          n;
        logic [31:0] total;
        logic [31:0] count;

        random_sent   = 0;
        send_idle_pct = 26;
        recv_idle_pct = 82;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings, track of one frame: frame zero is the final one and
        // lands in bucket zero, every later frame is past the end and lands in
        // the last bucket. Peaks climb through the corner codes.
        queue_frame(16'sd0, 16'sd0, 1'b0, 1'b0);
        queue_frame(16'sd1, -16'sd1, 1'b0, 1'b0);
        queue_frame(-16'sd2, 16'sd3, 1'b0, 1'b0);
        queue_frame(16'sd0, -16'sd5, 1'b0, 1'b0);
        queue_frame(16'sd100, -16'sd100, 1'b1, 1'b0);
        queue_frame(-16'sd300, 16'sd200, 1'b0, 1'b1);
        queue_frame(16'sd32767, -16'sd32768, 1'b1, 1'b1);
        queue_frame(-16'sd32768, 16'sd5, 1'b1, 1'b0);
        queue_frame(16'sd1000, -16'sd32767, 1'b0, 1'b0);
        queue_frame(16'sd32767, 16'sd0, 1'b0, 1'b0);
        queue_frame(-16'sd32768, -16'sd32768, 1'b0, 1'b0);
        queue_frame(16'sd0, 16'sd0, 1'b0, 1'b0);
        wait_drained();

        // Longest track in mono mode: everything falls in bucket zero, whose
        // peak is still zero, so the copied right channel and flag show up.
        write_reg(REG_TOTAL_FRAMES, 32'hFFFF_FFFF);
        write_reg(REG_MONO_MODE, 32'd1);
        queue_frame(16'sd7, -16'sd30000, 1'b0, 1'b0);
        queue_frame(-16'sd9, 16'sd30000, 1'b0, 1'b1);
        queue_frame(16'sd20, 16'sd0, 1'b1, 1'b0);
        queue_frame(-16'sd32768, 16'sd1000, 1'b1, 1'b1);
        queue_frame(-16'sd50, 16'sd32767, 1'b0, 1'b1);
        wait_drained();

        // A zero track length acts as one frame.
        write_reg(REG_TOTAL_FRAMES, 32'd0);
        write_reg(REG_MONO_MODE, 32'd0);
        queue_frame(16'sd0, 16'sd0, 1'b0, 1'b0);
        queue_frame(-16'sd32768, 16'sd4, 1'b0, 1'b0);
        queue_frame(16'sd12, -16'sd12, 1'b1, 1'b1);
        wait_drained();

        // Track ending four frames ahead: fresh buckets near the top, then the
        // final flag, then one frame past the end.
        write_reg(REG_TOTAL_FRAMES, track_frames + 32'd4);
        queue_frame(16'sd3, -16'sd4, 1'b0, 1'b0);
        queue_frame(16'sd0, -16'sd6, 1'b0, 1'b1);
        queue_frame(-16'sd8, 16'sd8, 1'b1, 1'b0);
        queue_frame(16'sd12, -16'sd13, 1'b0, 1'b0);
        queue_frame(16'sd1, 16'sd2, 1'b0, 1'b0);
        wait_drained();

        // Random settings. The frame counter is never cleared, so the track
        // length is picked relative to it: just ahead to catch the final
        // frame, well ahead to spread frames over low buckets, behind it to
        // saturate, or one of the extremes.
        while (random_sent < RANDOM_FRAMES) begin
            wait_drained();
            if (random_sent < RANDOM_FRAMES / 3) begin
                send_idle_pct = 26;
                recv_idle_pct = 82;
            end else if (random_sent < 2 * RANDOM_FRAMES / 3) begin
                send_idle_pct = 82;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            count = track_frames;
            case ($urandom_range(0, 7))
                0: total = 32'd0;
                1: total = 32'd1;
                2: total = 32'hFFFF_FFFF;
                3, 4: total = count + $urandom_range(1, 80);
                5: total = count * $urandom_range(2, 40);
                6: total = $urandom_range(1, count);
                default: total = $urandom;
            endcase
            write_reg(REG_TOTAL_FRAMES, total);
            write_reg(REG_MONO_MODE, cfg_data_t'($urandom_range(0, 2) == 0));
            n = $urandom_range(50, 90);
            repeat (n)
                queue_frame(random_sample(), random_sample(),
                            $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
            random_sent += n;
        end

        wait_drained();
        // The result path runs through the read stage and the output register; the wait
        // below catches any stray word.
        repeat (10) @(posedge aclk);
        $display("Checked %0d result words from %0d frames over %0d register writes.",
                 results_seen, frames_sent, regs_written);
        $display("Saw %0d final-frame flags; track lengths 0, 1 and 2^32-1, mono and stereo.",
                 finals_seen);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
